[rtl/imu_serial_frame_parser_core_defines.svh]
// Assertion macros shared by the frame parser modules.
`ifndef IMU_SERIAL_FRAME_PARSER_CORE_DEFINES_SVH
`define IMU_SERIAL_FRAME_PARSER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ISFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ISFP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ISFP_ASSERT(lbl, prop, msg)
`define ISFP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/isfp_pkg.sv]
// Types and constants of the serial frame parser.
`timescale 1ns / 1ps
`default_nettype none

package isfp_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'h55;
    localparam logic [7:0] TYPE_YAW  = 8'h53;
    localparam logic [7:0] TYPE_RATE = 8'h52;

    localparam logic [3:0] POS_HUNT      = 4'd0;
    localparam logic [3:0] POS_TYPE      = 4'd1;
    localparam logic [3:0] POS_PAY_FIRST = 4'd4;
    localparam logic [3:0] POS_PAY_LAST  = 4'd7;
    localparam logic [3:0] POS_CHECK     = 4'd10;

    localparam logic KIND_YAW  = 1'b0;
    localparam logic KIND_RATE = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_error;
    } t_in;

    typedef struct packed {
        logic               frame_kind;
        logic signed [15:0] yaw_raw;
        logic signed [15:0] rate_y_raw;
        logic signed [15:0] rate_z_raw;
        logic [31:0]        yaw_frames;
    } t_out;

    typedef struct packed {
        logic        commit;
        logic        kind;
        logic [15:0] word_a;
        logic [15:0] word_b;
    } t_frame_evt;

endpackage

`default_nettype wire

[rtl/isfp_in_if.sv]
// Byte channel into the frame parser.
`timescale 1ns / 1ps
`default_nettype none

interface isfp_in_if;
    logic           valid;
    logic           ready;
    isfp_pkg::t_in  payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/isfp_out_if.sv]
// Result channel out of the frame parser.
`timescale 1ns / 1ps
`default_nettype none

interface isfp_out_if;
    logic           valid;
    logic           ready;
    isfp_pkg::t_out payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/imu_serial_frame_parser_core.sv]
// Top level of the serial frame parser for an inertial sensor.
//
// The parser takes one received byte per transfer and can accept a byte in every clock
// cycle. Each byte is captured in an input register and is worked through the frame
// assembler from there; when it completes a frame whose checksum matches, the held
// yaw or y and z rates are updated and one result transfer, carrying every held value and
// the yaw frame count, is presented from the result register in the following cycle. The
// result register is the only stage that can stall the byte stream: the checksum byte of
// a good frame waits in the input register until the previous result has been taken, and
// all other bytes pass at one per cycle regardless.
// Bad frames, unknown frame types and bytes flagged with a line error produce no result.
`timescale 1ns / 1ps
`default_nettype none

module imu_serial_frame_parser_core (
    input  wire          i_clk,
    input  wire          i_rst_n,
    isfp_in_if.sink      i_in,
    isfp_out_if.source   o_out
);

    isfp_pkg::t_frame_evt evt;
    logic                 out_free;

    isfp_assembler u_assembler (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_out_free (out_free),
        .o_evt      (evt)
    );

    isfp_holder u_holder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt),
        .o_out_free (out_free),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

[rtl/isfp_assembler.sv]
// Input register and frame assembler with checksum check.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_serial_frame_parser_core_defines.svh"

module isfp_assembler (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    isfp_in_if.sink                i_in,
    input  wire                    i_out_free,
    output isfp_pkg::t_frame_evt   o_evt
);

    logic             r_s1_valid;
    isfp_pkg::t_in    r_in;
    logic [3:0]       r_pos;
    logic [3:0]       n_pos;
    logic [7:0]       r_sum;
    logic [7:0]       n_sum;
    logic             r_type;
    logic             n_type;
    logic [7:0]       r_payload [4];
    logic [7:0]       n_payload [4];
    logic             frame_ok;
    logic             advance;

    always_comb begin
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_type    = r_type;
        n_payload = r_payload;
        frame_ok  = 1'b0;
        if (r_in.line_error) begin
            n_pos = isfp_pkg::POS_HUNT;
            n_sum = '0;
        end else if (r_pos == isfp_pkg::POS_HUNT || r_pos > isfp_pkg::POS_CHECK) begin
            if (r_in.rx_byte == isfp_pkg::HDR_BYTE) begin
                n_pos = isfp_pkg::POS_TYPE;
                n_sum = isfp_pkg::HDR_BYTE;
            end else begin
                n_pos = isfp_pkg::POS_HUNT;
            end
        end else if (r_pos == isfp_pkg::POS_TYPE) begin
            if (r_in.rx_byte == isfp_pkg::TYPE_YAW || r_in.rx_byte == isfp_pkg::TYPE_RATE) begin
                n_type = (r_in.rx_byte == isfp_pkg::TYPE_RATE) ? isfp_pkg::KIND_RATE
                                                               : isfp_pkg::KIND_YAW;
                n_sum  = 8'(r_sum + r_in.rx_byte);
                n_pos  = 4'(r_pos + 4'd1);
            end else if (r_in.rx_byte == isfp_pkg::HDR_BYTE) begin
                n_pos = isfp_pkg::POS_TYPE;
                n_sum = isfp_pkg::HDR_BYTE;
            end else begin
                n_pos = isfp_pkg::POS_HUNT;
            end
        end else if (r_pos < isfp_pkg::POS_CHECK) begin
            n_sum = 8'(r_sum + r_in.rx_byte);
            if (r_pos >= isfp_pkg::POS_PAY_FIRST && r_pos <= isfp_pkg::POS_PAY_LAST) begin
                n_payload[r_pos[1:0]] = r_in.rx_byte;
            end
            n_pos = 4'(r_pos + 4'd1);
        end else begin
            n_pos    = isfp_pkg::POS_HUNT;
            n_sum    = '0;
            frame_ok = r_s1_valid && (r_sum == r_in.rx_byte);
        end
    end

    // A good frame may only leave when the result register can take it.
    assign advance    = r_s1_valid && (!frame_ok || i_out_free);
    assign i_in.ready = !r_s1_valid || advance;

    assign o_evt.commit = frame_ok && advance;
    assign o_evt.kind   = r_type;
    assign o_evt.word_a = {r_payload[1], r_payload[0]};
    assign o_evt.word_b = {r_payload[3], r_payload[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_pos      <= isfp_pkg::POS_HUNT;
            r_sum      <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_pos <= n_pos;
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
        if (advance) begin
            r_type    <= n_type;
            r_payload <= n_payload;
        end
    end

    `ISFP_ASSERT(a_pos_in_range, r_pos <= isfp_pkg::POS_CHECK, "Byte position out of range.")
    `ISFP_ASSERT(a_commit_at_check, o_evt.commit |-> r_pos == isfp_pkg::POS_CHECK && i_out_free, "Frame committed outside the checksum byte or into a full result register.")
    `ISFP_ASSERT(a_error_clears, (advance && r_in.line_error) |=> r_pos == isfp_pkg::POS_HUNT && r_sum == 8'd0, "Line error did not reset assembly.")
    `ISFP_ASSERT(a_stall_holds_state, (r_s1_valid && !advance) |=> $stable(r_pos) && $stable(r_sum), "Assembly state moved while stalled.")

endmodule

`default_nettype wire

[rtl/isfp_holder.sv]
// Held sensor values, yaw frame counter and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_serial_frame_parser_core_defines.svh"

module isfp_holder (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  isfp_pkg::t_frame_evt   i_evt,
    output logic                   o_out_free,
    isfp_out_if.source             o_out
);

    logic           r_out_valid;
    isfp_pkg::t_out r_out;
    logic [15:0]    r_yaw;
    logic [15:0]    n_yaw;
    logic [15:0]    r_rate_y;
    logic [15:0]    n_rate_y;
    logic [15:0]    r_rate_z;
    logic [15:0]    n_rate_z;
    logic [31:0]    r_count;
    logic [31:0]    n_count;

    always_comb begin
        n_yaw    = r_yaw;
        n_rate_y = r_rate_y;
        n_rate_z = r_rate_z;
        n_count  = r_count;
        if (i_evt.commit) begin
            if (i_evt.kind == isfp_pkg::KIND_YAW) begin
                n_yaw   = i_evt.word_b;
                n_count = 32'(r_count + 32'd1);
            end else begin
                n_rate_y = i_evt.word_a;
                n_rate_z = i_evt.word_b;
            end
        end
    end

    assign o_out_free    = !r_out_valid || o_out.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_yaw       <= '0;
            r_rate_y    <= '0;
            r_rate_z    <= '0;
            r_count     <= '0;
        end else begin
            if (i_evt.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_yaw    <= n_yaw;
            r_rate_y <= n_rate_y;
            r_rate_z <= n_rate_z;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.commit) begin
            r_out.frame_kind <= i_evt.kind;
            r_out.yaw_raw    <= $signed(n_yaw);
            r_out.rate_y_raw <= $signed(n_rate_y);
            r_out.rate_z_raw <= $signed(n_rate_z);
            r_out.yaw_frames <= n_count;
        end
    end

    `ISFP_ASSERT(a_commit_fills, i_evt.commit |=> r_out_valid, "Committed frame did not reach the result register.")
    `ISFP_ASSERT(a_yaw_counts, (i_evt.commit && i_evt.kind == isfp_pkg::KIND_YAW) |=> r_count == 32'($past(r_count) + 32'd1), "Yaw frame not counted.")
    `ISFP_ASSERT(a_rate_no_count, (i_evt.commit && i_evt.kind == isfp_pkg::KIND_RATE) |=> $stable(r_count) && $stable(r_yaw), "Rate frame touched yaw state.")
    `ISFP_ASSERT(a_idle_holds, !i_evt.commit |=> $stable(r_count) && $stable(r_rate_y) && $stable(r_rate_z), "Held values moved without a frame.")

endmodule

`default_nettype wire
